FILE: rtl/vwbp_pkg.sv
// Package with the item types and fixed widths of the variable width bit packer.
package vwbp_pkg;

  localparam int BYTE_W  = 8;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 6;
  localparam int TOTAL_W = 32;
  localparam int PCNT_W  = 3;
  localparam int STEP_W  = 4;

  // Request kinds.
  localparam logic KIND_APPEND = 1'b0;
  localparam logic KIND_FLUSH  = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [COUNT_W-1:0] bit_count;
    logic [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  out_byte;
    logic [TOTAL_W-1:0] bytes_written;
    logic               last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic flush;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rem_zero;
    logic step_done;
    logic out_free;
  } dp_status_t;

  // Reverses the bit order of a byte.
  function automatic logic [BYTE_W-1:0] bit_reverse(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] r;
    for (int i = 0; i < BYTE_W; i++) begin
      r[i] = b[BYTE_W-1-i];
    end
    return r;
  endfunction

endpackage

FILE: rtl/vwbp_stream_if.sv
// Valid/ready stream interface carrying one payload of a given type.
interface vwbp_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/variable_width_bit_packer.sv
// Top level of the variable width bit packer: controller, datapath and stream ports.
//
// Requests arrive on the cmd stream. An append request (kind 0) takes the low
// bit_count bits of value, least significant first, saturating bit_count to
// MAX_WIDTH; a flush request (kind 1) emits any partial byte left-aligned and
// zero padded. Packed bytes leave on the bytes stream with the running total
// of bytes emitted and a last flag on the final byte a request causes.
// The block takes one request at a time: it accepts a request only in idle,
// then makes one append step per cycle while the output register is free,
// where a step fills the current byte or uses up the remaining bits. A
// zero-width append and a flush make no append step. Each byte is written
// to the output register by the step or flush that completes it. The
// single output register sets the pace: a step waits while that register
// holds a byte the receiver has not taken, so a stalled receiver stalls the
// packer without losing bytes. Synchronous reset clears pending bits, the
// byte count and the output valid flag.
module variable_width_bit_packer #(
  parameter int MAX_WIDTH = 32
) (
  input logic                  clk,
  input logic                  rst,
  vwbp_stream_if.sink          cmd,
  vwbp_stream_if.source        bytes
);

  vwbp_pkg::dp_cmd_t    dp_cmd;
  vwbp_pkg::dp_status_t dp_status;
  vwbp_pkg::in_item_t   in_item;
  vwbp_pkg::out_item_t  out_item;

  assign in_item       = cmd.payload;
  assign bytes.payload = out_item;

  // Sequencing of each request.
  vwbp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_kind  (in_item.kind),
    .in_ready (cmd.ready),
    .status   (dp_status),
    .cmd      (dp_cmd)
  );

  // Bit accumulation and output register.
  vwbp_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cmd       (dp_cmd),
    .status    (dp_status),
    .out_valid (bytes.valid),
    .out_ready (bytes.ready),
    .out_item  (out_item)
  );

endmodule

FILE: rtl/vwbp_ctrl.sv
// Controller state machine of the bit packer: sequences load, append steps and flush.
module vwbp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_kind,
  output logic                 in_ready,
  input  vwbp_pkg::dp_status_t status,
  output vwbp_pkg::dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    IDLE   = 3'b001,
    APPEND = 3'b010,
    FLUSH  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_kind == vwbp_pkg::KIND_FLUSH) begin
            state_next = FLUSH;
          end else begin
            state_next = APPEND;
          end
        end
      end
      APPEND: begin
        if (status.rem_zero) begin
          state_next = IDLE;
        end else if (status.out_free) begin
          cmd.step = 1'b1;
          if (status.step_done) begin
            state_next = IDLE;
          end
        end
      end
      FLUSH: begin
        if (status.out_free) begin
          cmd.flush  = 1'b1;
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/vwbp_datapath.sv
// Datapath of the bit packer: work registers, byte accumulator, counter and output register.
module vwbp_datapath #(
  parameter int MAX_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  vwbp_pkg::in_item_t           in_item,
  input  vwbp_pkg::dp_cmd_t            cmd,
  output vwbp_pkg::dp_status_t         status,
  output logic                         out_valid,
  input  logic                         out_ready,
  output vwbp_pkg::out_item_t          out_item
);

  localparam int REM_W = $clog2(MAX_WIDTH + 1);
  localparam int BW    = vwbp_pkg::BYTE_W;
  localparam int SW    = vwbp_pkg::STEP_W;
  localparam int CW    = (REM_W > SW) ? REM_W : SW;
  localparam int MW    = $clog2(2 * BW + 1);

  logic [vwbp_pkg::VALUE_W-1:0] work_value;
  logic [REM_W-1:0]             rem;
  logic [BW-1:0]                pending_bits;
  logic [vwbp_pkg::PCNT_W-1:0]  pending_count;
  logic [vwbp_pkg::TOTAL_W-1:0] byte_total;

  logic [REM_W-1:0] sat_count;
  logic [SW-1:0]    space;
  logic [SW-1:0]    take;
  logic [SW-1:0]    fill;
  logic [BW-1:0]    chunk_rev;
  logic [2*BW-1:0]  merged;
  logic [BW-1:0]    flush_byte;
  logic [REM_W-1:0] rem_after;
  logic             last_byte;
  logic             out_free;

  // Saturate the requested width to the maximum.
  always_comb begin
    if ({1'b0, in_item.bit_count} > 7'(MAX_WIDTH)) begin
      sat_count = REM_W'(MAX_WIDTH);
    end else begin
      sat_count = REM_W'(in_item.bit_count);
    end
  end

  // One append step takes as many of the remaining bits as fit into the current byte.
  always_comb begin
    space = SW'(BW) - SW'(pending_count);
    if (CW'(rem) < CW'(space)) begin
      take = SW'(rem);
    end else begin
      take = space;
    end
    fill       = SW'(pending_count) + take;
    chunk_rev  = vwbp_pkg::bit_reverse(work_value[BW-1:0]);
    merged     = ({{BW{1'b0}}, pending_bits} << take) |
                 ({chunk_rev, {BW{1'b0}}} >> (MW'(2 * BW) - MW'(take)));
    flush_byte = pending_bits << (SW'(BW) - SW'(pending_count));
    // A byte completed by this step is the last one when too few bits remain for another.
    rem_after  = rem - REM_W'(take);
    last_byte  = (int'(rem_after) < BW);
  end

  assign out_free         = !out_valid || out_ready;
  assign status.out_free  = out_free;
  assign status.rem_zero  = (rem == '0);
  assign status.step_done = (CW'(rem) == CW'(take));

  // Work registers for the item being appended.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      work_value <= in_item.value;
      if (in_item.kind == vwbp_pkg::KIND_APPEND) begin
        rem <= sat_count;
      end else begin
        rem <= '0;
      end
    end else if (cmd.step) begin
      work_value <= work_value >> take;
      rem        <= rem_after;
    end
  end

  // Byte accumulator, running byte count and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits  <= '0;
      pending_count <= '0;
      byte_total    <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.step) begin
        if (fill == SW'(BW)) begin
          pending_bits           <= '0;
          pending_count          <= '0;
          byte_total             <= byte_total + 1'b1;
          out_valid              <= 1'b1;
          out_item.out_byte      <= merged[BW-1:0];
          out_item.bytes_written <= byte_total + 1'b1;
          out_item.last          <= last_byte;
        end else begin
          pending_bits  <= merged[BW-1:0];
          pending_count <= fill[vwbp_pkg::PCNT_W-1:0];
        end
      end else if (cmd.flush && pending_count != '0) begin
        pending_bits           <= '0;
        pending_count          <= '0;
        byte_total             <= byte_total + 1'b1;
        out_valid              <= 1'b1;
        out_item.out_byte      <= flush_byte;
        out_item.bytes_written <= byte_total + 1'b1;
        out_item.last          <= 1'b1;
      end
    end
  end

endmodule

FILE: bench/tb_variable_width_bit_packer.sv
// Self-checking testbench for the variable width bit packer: directed, stall and random requests.
module tb_variable_width_bit_packer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_WIDTH   = 32;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN_WAIT  = 20;

  logic clk;
  logic rst;

  vwbp_stream_if #(.payload_t(vwbp_pkg::in_item_t))  cmd_if ();
  vwbp_stream_if #(.payload_t(vwbp_pkg::out_item_t)) byte_if ();

  variable_width_bit_packer #(
    .MAX_WIDTH(MAX_WIDTH)
  ) i_dut (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd_if.sink),
    .bytes(byte_if.source)
  );

  // Shadow state of the packer and the bytes it still owes.
  logic [7:0]          shadow_bits;
  int                  shadow_count;
  logic [31:0]         shadow_total;
  vwbp_pkg::out_item_t expected_bytes[$];

  bit idle_enable;
  bit long_hold_req;
  int fail_count;
  int requests_sent;
  int flushes_sent;
  int bytes_checked;
  int cycle_count;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Works out the bytes that one accepted request produces and queues them.
  function automatic void pack_request(input vwbp_pkg::in_item_t req);
    int                  width;
    int                  first;
    logic                bit_in;
    vwbp_pkg::out_item_t produced;
    first = expected_bytes.size();
    if (req.kind == vwbp_pkg::KIND_FLUSH) begin
      if (shadow_count != 0) begin
        shadow_total = shadow_total + 32'd1;
        produced.out_byte      = shadow_bits << (8 - shadow_count);
        produced.bytes_written = shadow_total;
        produced.last          = 1'b0;
        expected_bytes.push_back(produced);
        shadow_bits  = '0;
        shadow_count = 0;
      end
    end else begin
      width = (int'(req.bit_count) > MAX_WIDTH) ? MAX_WIDTH : int'(req.bit_count);
      for (int i = 0; i < width; i++) begin
        bit_in = (i < 32) ? req.value[i] : 1'b0;
        shadow_bits = {shadow_bits[6:0], bit_in};
        shadow_count++;
        if (shadow_count == 8) begin
          shadow_total = shadow_total + 32'd1;
          produced.out_byte      = shadow_bits;
          produced.bytes_written = shadow_total;
          produced.last          = 1'b0;
          expected_bytes.push_back(produced);
          shadow_bits  = '0;
          shadow_count = 0;
        end
      end
    end
    // The final byte of a request carries the last flag.
    if (expected_bytes.size() > first) begin
      expected_bytes[expected_bytes.size() - 1].last = 1'b1;
    end
  endfunction

  // Sends one request, with an optional idle burst before it, and waits for acceptance.
  task automatic send_request(input logic kind, input logic [5:0] bit_count,
                              input logic [31:0] value);
    vwbp_pkg::in_item_t req;
    req.kind      = kind;
    req.bit_count = bit_count;
    req.value     = value;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    cmd_if.payload = req;
    cmd_if.valid   = 1'b1;
    do @(posedge clk); while (!cmd_if.ready);
    pack_request(req);
    requests_sent++;
    if (kind == vwbp_pkg::KIND_FLUSH) flushes_sent++;
    @(negedge clk);
    cmd_if.valid = 1'b0;
  endtask

  // Picks a random request, mostly appends of ordinary widths.
  task automatic send_random_request();
    int choice;
    choice = $urandom_range(0, 9);
    if (choice < 2) begin
      send_request(vwbp_pkg::KIND_FLUSH, 6'($urandom_range(0, 63)), $urandom);
    end else if (choice == 2) begin
      send_request(vwbp_pkg::KIND_APPEND, 6'($urandom_range(33, 63)), $urandom);
    end else if (choice == 3) begin
      send_request(vwbp_pkg::KIND_APPEND, 6'($urandom_range(0, 7)), $urandom);
    end else begin
      send_request(vwbp_pkg::KIND_APPEND, 6'($urandom_range(1, 32)), $urandom);
    end
  endtask

  // Waits until every expected byte has arrived, then lets the block settle.
  task automatic wait_for_drain();
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    @(negedge clk);
  endtask

  // Field extremes, zero width, empty and partial flushes, saturated widths.
  task automatic test_edge_cases();
    send_request(vwbp_pkg::KIND_APPEND, 6'd8,  32'h0000_00B1);
    send_request(vwbp_pkg::KIND_APPEND, 6'd0,  32'hFFFF_FFFF);
    send_request(vwbp_pkg::KIND_FLUSH,  6'd63, 32'hFFFF_FFFF);
    send_request(vwbp_pkg::KIND_APPEND, 6'd3,  32'h0000_0005);
    send_request(vwbp_pkg::KIND_FLUSH,  6'd17, 32'h1234_5678);
    send_request(vwbp_pkg::KIND_FLUSH,  6'd0,  32'h0000_0000);
    send_request(vwbp_pkg::KIND_APPEND, 6'd32, 32'hFFFF_FFFF);
    send_request(vwbp_pkg::KIND_APPEND, 6'd32, 32'h0000_0000);
    send_request(vwbp_pkg::KIND_APPEND, 6'd63, 32'h1234_5678);
    send_request(vwbp_pkg::KIND_APPEND, 6'd33, 32'h8000_0001);
    send_request(vwbp_pkg::KIND_APPEND, 6'd1,  32'h0000_0001);
    send_request(vwbp_pkg::KIND_APPEND, 6'd31, 32'hDEAD_BEEF);
    send_request(vwbp_pkg::KIND_APPEND, 6'd7,  32'h0000_007F);
    send_request(vwbp_pkg::KIND_APPEND, 6'd1,  32'h0000_0000);
    send_request(vwbp_pkg::KIND_APPEND, 6'd5,  32'h0000_0013);
    send_request(vwbp_pkg::KIND_FLUSH,  6'd32, 32'hFFFF_FFFF);
    send_request(vwbp_pkg::KIND_APPEND, 6'd2,  32'h0000_0002);
    send_request(vwbp_pkg::KIND_APPEND, 6'd40, 32'h0000_0000);
    send_request(vwbp_pkg::KIND_FLUSH,  6'd1,  32'h0000_0001);
    send_request(vwbp_pkg::KIND_APPEND, 6'd32, 32'hAAAA_AAAA);
    send_request(vwbp_pkg::KIND_APPEND, 6'd32, 32'h5555_5555);
    send_request(vwbp_pkg::KIND_APPEND, 6'd6,  32'h0000_002A);
    send_request(vwbp_pkg::KIND_FLUSH,  6'd0,  32'h0000_0000);
    // A byte count wrap would need 2^32 bytes, far beyond any sensible run.
    wait_for_drain();
  endtask

  // The receiver holds off for a long stretch while full-width appends keep coming.
  task automatic test_stalled_receiver();
    long_hold_req = 1'b1;
    for (int i = 0; i < 24; i++) begin
      send_request(vwbp_pkg::KIND_APPEND, 6'd32, $urandom);
    end
    send_request(vwbp_pkg::KIND_FLUSH, 6'($urandom_range(0, 63)), $urandom);
    wait_for_drain();
  endtask

  // Random requests with idling on both sides, then a final stretch without any.
  task automatic test_random_stream();
    for (int i = 0; i < 165; i++) begin
      send_random_request();
    end
    idle_enable = 1'b0;
    for (int i = 0; i < 60; i++) begin
      send_random_request();
    end
    send_request(vwbp_pkg::KIND_FLUSH, 6'd0, 32'h0000_0000);
    wait_for_drain();
  endtask

  // Receiver: random stall bursts, plus one long hold-off when asked for.
  initial begin : receiver
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    byte_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        hold_left     = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        byte_if.ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        byte_if.ready = 1'b0;
      end else if (idle_enable && $urandom_range(0, 3) == 0) begin
        stall_left    = $urandom_range(1, 8) - 1;
        byte_if.ready = 1'b0;
      end else begin
        byte_if.ready = 1'b1;
      end
    end
  end

  // Compares every byte taken from the block with the oldest expected one.
  always @(posedge clk) begin
    vwbp_pkg::out_item_t want;
    if (!rst && byte_if.valid && byte_if.ready) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected byte %02h count %0d last %0b", $time,
                 byte_if.payload.out_byte, byte_if.payload.bytes_written,
                 byte_if.payload.last);
        fail_count++;
      end else begin
        want = expected_bytes.pop_front();
        bytes_checked++;
        if (byte_if.payload.out_byte !== want.out_byte) begin
          $display("%0t: out_byte expected %02h, actual %02h", $time,
                   want.out_byte, byte_if.payload.out_byte);
          fail_count++;
        end
        if (byte_if.payload.bytes_written !== want.bytes_written) begin
          $display("%0t: bytes_written expected %0d, actual %0d", $time,
                   want.bytes_written, byte_if.payload.bytes_written);
          fail_count++;
        end
        if (byte_if.payload.last !== want.last) begin
          $display("%0t: last expected %0b, actual %0b", $time,
                   want.last, byte_if.payload.last);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: ends a run that hangs.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles", cycle_count);
    $display("Verification failed");
    $finish;
  end

  // Test sequence.
  initial begin
    rst            = 1'b1;
    cmd_if.valid   = 1'b0;
    cmd_if.payload = '0;
    idle_enable    = 1'b1;
    long_hold_req  = 1'b0;
    fail_count     = 0;
    requests_sent  = 0;
    flushes_sent   = 0;
    bytes_checked  = 0;
    shadow_bits    = '0;
    shadow_count   = 0;
    shadow_total   = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_edge_cases();
    test_stalled_receiver();
    test_random_stream();

    $display("Sent %0d requests (%0d flushes), checked %0d packed bytes,",
             requests_sent, flushes_sent, bytes_checked);
    $display("including saturated widths, empty flushes and a long receiver stall.");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
